// File: rtl/rsfr_pkg.sv
// ----------------------------------------------------------------------------
// rsfr_pkg
// shared constants and types of the serial radio-control frame receiver
// ----------------------------------------------------------------------------
package rsfr_pkg;

    localparam int unsigned FRAME_LAST_POS = 31;
    localparam int unsigned SUM_LOW_POS    = 30;
    localparam int unsigned PAYLOAD_FIRST  = 2;
    localparam int unsigned MAX_CHANNELS   = 14;

    localparam logic [4:0] POS_HEADER_FIRST  = 5'd0;
    localparam logic [4:0] POS_HEADER_SECOND = 5'd1;
    localparam logic [4:0] POS_PAYLOAD_FIRST = 5'(PAYLOAD_FIRST);
    localparam logic [4:0] POS_SUM_LOW       = 5'(SUM_LOW_POS);
    localparam logic [4:0] POS_SUM_HIGH      = 5'(FRAME_LAST_POS);

    localparam logic [7:0]  HEADER_FIRST_RESET  = 8'h20;
    localparam logic [7:0]  HEADER_SECOND_RESET = 8'h40;
    localparam logic [15:0] SUM_SEED            = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

    localparam int unsigned CH_IDX_W = 4;
    localparam int unsigned VALUE_W  = 16;

    // one channel word written into the frame store
    typedef struct packed {
        logic                en;
        logic                bank;
        logic [CH_IDX_W-1:0] ch;
        logic [VALUE_W-1:0]  data;
    } t_store_wr;

    // bank handed back to the front once all its channels are out
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_release;

endpackage

// File: rtl/rsfr_front.sv
// ----------------------------------------------------------------------------
// rsfr_front
// byte parser: header match, checksum, channel word writes, frame commit
// ----------------------------------------------------------------------------
module rsfr_front #(
    parameter int unsigned NUM_CHANNELS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_full,
    input  logic [7:0]                 i_header_first,
    input  logic [7:0]                 i_header_second,
    output rsfr_pkg::t_store_wr        o_store_wr,
    output logic                       o_commit,
    output logic                       o_commit_bank,
    input  rsfr_pkg::t_bank_release    i_release
);

    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_sum_lo, n_sum_lo;
    logic        r_wbank, n_wbank;
    logic [1:0]  r_busy, n_busy;

    logic        accept;
    logic        in_payload;
    logic [4:0]  pay_off;
    logic [15:0] sum_less;
    logic        commit;
    logic [1:0]  set_mask;
    logic [1:0]  clr_mask;

    assign in_payload = (r_pos >= rsfr_pkg::POS_PAYLOAD_FIRST)
                     && (r_pos < rsfr_pkg::POS_SUM_LOW);
    // a payload byte waits while its bank still holds a frame not yet fully read out
    assign o_full   = in_payload && r_busy[r_wbank];
    assign accept   = i_push && !o_full;
    assign pay_off  = r_pos - rsfr_pkg::POS_PAYLOAD_FIRST;
    assign sum_less = r_sum - {8'h00, i_rx_byte};
    assign commit   = accept && (r_pos == rsfr_pkg::POS_SUM_HIGH)
                   && ({i_rx_byte, r_sum_lo} == r_sum);

    always_comb begin
        o_store_wr.en   = accept && in_payload && pay_off[0]
                       && (pay_off[4:1] < rsfr_pkg::CH_IDX_W'(NUM_CHANNELS));
        o_store_wr.bank = r_wbank;
        o_store_wr.ch   = pay_off[4:1];
        o_store_wr.data = {i_rx_byte, r_lo};
    end

    assign o_commit      = commit;
    assign o_commit_bank = r_wbank;

    always_comb begin
        set_mask = 2'b00;
        clr_mask = 2'b00;
        if (commit) begin
            set_mask[r_wbank] = 1'b1;
        end
        if (i_release.valid) begin
            clr_mask[i_release.bank] = 1'b1;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_lo     = r_lo;
        n_sum_lo = r_sum_lo;
        n_wbank  = r_wbank ^ commit;
        n_busy   = (r_busy & ~clr_mask) | set_mask;
        if (accept) begin
            if (r_pos == rsfr_pkg::POS_HEADER_FIRST) begin
                if (i_rx_byte == i_header_first) begin
                    n_sum = rsfr_pkg::SUM_SEED - {8'h00, i_rx_byte};
                    n_pos = rsfr_pkg::POS_HEADER_SECOND;
                end
            end else if (r_pos == rsfr_pkg::POS_HEADER_SECOND) begin
                if (i_rx_byte == i_header_second) begin
                    n_sum = sum_less;
                    n_pos = rsfr_pkg::POS_PAYLOAD_FIRST;
                end else begin
                    n_pos = rsfr_pkg::POS_HEADER_FIRST;
                end
            end else if (in_payload) begin
                n_sum = sum_less;
                n_lo  = i_rx_byte;
                n_pos = r_pos + 5'd1;
            end else if (r_pos == rsfr_pkg::POS_SUM_LOW) begin
                n_sum_lo = i_rx_byte;
                n_pos    = rsfr_pkg::POS_SUM_HIGH;
            end else begin
                n_pos = rsfr_pkg::POS_HEADER_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= rsfr_pkg::POS_HEADER_FIRST;
            r_sum   <= rsfr_pkg::SUM_SEED;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_sum_lo <= n_sum_lo;
    end

    // a frame is only ever committed into a bank nobody is reading
    a_commit_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> !r_busy[r_wbank])
        else $error("frame committed into a busy bank");

    // a bank is only released while it is still marked busy
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release.valid |-> r_busy[i_release.bank])
        else $error("release of a bank that was not busy");

endmodule

// File: rtl/rsfr_queue.sv
// ----------------------------------------------------------------------------
// rsfr_queue
// two-entry queue of committed bank numbers between front and back
// ----------------------------------------------------------------------------
module rsfr_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_data,
    input  logic i_pop,
    output logic o_empty,
    output logic o_data
);

    logic [1:0] r_mem;
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2) || i_pop)
        else $error("bank queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("bank queue underflow");

endmodule

// File: rtl/rsfr_back.sv
// ----------------------------------------------------------------------------
// rsfr_back
// frame store and channel sequencer feeding the result register
// ----------------------------------------------------------------------------
module rsfr_back #(
    parameter int unsigned NUM_CHANNELS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsfr_pkg::t_store_wr        i_store_wr,
    input  logic                       i_q_empty,
    input  logic                       i_q_bank,
    output logic                       o_q_pop,
    output rsfr_pkg::t_bank_release    o_release,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [3:0]                 o_channel_index,
    output logic [15:0]                o_channel_value,
    output logic                       o_last_channel
);

    localparam int unsigned DEPTH = 2 * NUM_CHANNELS;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [15:0]     r_store [DEPTH];
    logic            r_active;
    logic            r_bank;
    logic [CH_W-1:0] r_ch;
    logic            r_out_valid;
    logic [3:0]      r_out_idx;
    logic [15:0]     r_out_val;
    logic            r_out_last;

    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             load;
    logic             ch_last;
    logic             start;

    assign wr_idx = i_store_wr.bank
                  ? IDX_W'(NUM_CHANNELS) + IDX_W'(i_store_wr.ch)
                  : IDX_W'(i_store_wr.ch);
    assign rd_idx = r_bank ? IDX_W'(NUM_CHANNELS) + IDX_W'(r_ch) : IDX_W'(r_ch);

    assign ch_last = (r_ch == CH_W'(NUM_CHANNELS - 1));
    // result register frees up either empty or being taken this cycle
    assign load    = r_active && (!r_out_valid || i_pop);
    assign start   = !r_active && !i_q_empty;

    assign o_q_pop         = start;
    assign o_release.valid = load && ch_last;
    assign o_release.bank  = r_bank;

    assign o_empty         = !r_out_valid;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_last_channel  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[wr_idx] <= i_store_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_active <= 1'b1;
            end else if (load && ch_last) begin
                r_active <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_bank <= i_q_bank;
            r_ch   <= '0;
        end else if (load) begin
            r_ch <= r_ch + CH_W'(1);
        end
        if (load) begin
            r_out_idx  <= 4'(r_ch);
            r_out_val  <= r_store[rd_idx];
            r_out_last <= ch_last;
        end
    end

    // every readout starts from the first channel
    a_start_first_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_active && (r_ch == '0))
        else $error("readout did not start at channel zero");

endmodule

// File: rtl/rc_serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver_unit
// receives 32-byte radio-control frames a byte at a time and emits the
// channel values of every frame whose checksum holds
// ----------------------------------------------------------------------------
//  channel   | signals                                   | beat
//  ----------+-------------------------------------------+--------------------------
//  bytes in  | push, full, i_rx_byte                     | push & !full
//  results   | pop, empty, o_channel_index/value/last    | pop & !empty
//  registers | psel, penable, pwrite, paddr, pwdata, ... | psel & penable & pwrite
//
//  full rises only for payload bytes while both frame store banks still hold
//  frames waiting to be read out
//  a good frame yields NUM_CHANNELS results, one a cycle from the sequencer while
//  results are popped at once; its bank number goes through the queue and the
//  sequencer start before the first result, and pop stalls hold the sequencer too
//  reset is synchronous, active low; header registers return to 0x20 / 0x40
//  there is no clearing pass, the frame store is written before it is read
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver_unit #(
    parameter int unsigned NUM_CHANNELS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result output
    input  logic        pop,
    output logic        empty,
    output logic [3:0]  o_channel_index,
    output logic [15:0] o_channel_value,
    output logic        o_last_channel,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // header registers
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic       cfg_wr;
    logic       cfg_sel;

    // front to back
    rsfr_pkg::t_store_wr     store_wr;
    rsfr_pkg::t_bank_release bank_release;
    logic                    commit;
    logic                    commit_bank;
    logic                    q_empty;
    logic                    q_bank;
    logic                    q_pop;

    assign pready  = 1'b1;
    // word address: register index sits right above the byte offset
    assign cfg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_sel)
            rsfr_pkg::REG_HEADER_FIRST:  prdata = {24'h000000, r_header_first};
            rsfr_pkg::REG_HEADER_SECOND: prdata = {24'h000000, r_header_second};
            default:                     prdata = 32'h00000000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= rsfr_pkg::HEADER_FIRST_RESET;
            r_header_second <= rsfr_pkg::HEADER_SECOND_RESET;
        end else if (cfg_wr) begin
            if (cfg_sel == rsfr_pkg::REG_HEADER_FIRST) begin
                r_header_first <= pwdata[7:0];
            end else begin
                r_header_second <= pwdata[7:0];
            end
        end
    end

    // parser: header check, running checksum, channel words into the store
    rsfr_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_rx_byte       (i_rx_byte),
        .o_full          (full),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_store_wr      (store_wr),
        .o_commit        (commit),
        .o_commit_bank   (commit_bank),
        .i_release       (bank_release)
    );

    // committed frames wait here as bank numbers
    rsfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (commit),
        .i_data  (commit_bank),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_bank)
    );

    // sequencer: walks the channels of one bank into the result register
    rsfr_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_store_wr      (store_wr),
        .i_q_empty       (q_empty),
        .i_q_bank        (q_bank),
        .o_q_pop         (q_pop),
        .o_release       (bank_release),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    // a result carrying the last-channel mark always names the final channel
    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_channel) |-> (o_channel_index == 4'(NUM_CHANNELS - 1)))
        else $error("last mark on a channel other than the final one");

endmodule
